### hdl/tnlf_pkg.sv
// Shared constants and types for the top-N largest files selector.
`default_nettype none

package tnlf_pkg;

   // Fixed field widths
   localparam int SIZE_BITS = 48;
   localparam int RANK_BITS = 4;
   localparam int KEEP_BITS = 5;

   // Defaults for the top-level parameters
   localparam int MAX_KEEP_DEF   = 16;
   localparam int INDEX_BITS_DEF = 20;

   // keep_count after reset
   localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd16;

   // Input word opcodes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_END    = 1'b1;

   // Snapshot control from the sorting row into the output row
   typedef struct packed {
      logic en;        // take a snapshot this cycle
      logic empty;     // nothing to report, emit one empty word
      logic overflow;  // arrivals were dropped in this set
   } tnlf_load_type;

endpackage

`default_nettype wire

### hdl/tnlf_cell.sv
// One cell of the sorted insertion row: holds one entry and shifts it down.
`default_nettype none

module tnlf_cell #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           ins_en,
   input  wire logic                           clear,
   input  wire logic [tnlf_pkg::SIZE_BITS-1:0] new_size,
   input  wire logic [INDEX_BITS-1:0]          new_index,
   input  wire logic                           prev_take,
   input  wire logic                           prev_valid,
   input  wire logic [tnlf_pkg::SIZE_BITS-1:0] prev_size,
   input  wire logic [INDEX_BITS-1:0]          prev_index,
   output      logic                           take,
   output      logic                           valid,
   output      logic [tnlf_pkg::SIZE_BITS-1:0] size,
   output      logic [INDEX_BITS-1:0]          index
);
   import tnlf_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [SIZE_BITS-1:0]  size_ff;
   logic [SIZE_BITS-1:0]  size_in;
   logic [INDEX_BITS-1:0] index_ff;
   logic [INDEX_BITS-1:0] index_in;

   // New word belongs at or above this slot; equal sizes stay behind
   assign take = !valid_ff || (new_size > size_ff);

   // Either shift the upstream entry in or take the new word here
   always_comb begin
      if (prev_take) begin
         valid_in = prev_valid;
         size_in  = prev_size;
         index_in = prev_index;
      end else begin
         valid_in = 1'b1;
         size_in  = new_size;
         index_in = new_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (ins_en && take) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_en && take) begin
         size_ff  <= size_in;
         index_ff <= index_in;
      end
   end

   assign valid = valid_ff;
   assign size  = size_ff;
   assign index = index_ff;

endmodule

`default_nettype wire

### hdl/tnlf_drain.sv
// Output row: snapshot of top entries, one word out per cycle unless stalled.
`default_nettype none

module tnlf_drain #(
   parameter int MAX_KEEP   = 16,
   parameter int INDEX_BITS = 20
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire tnlf_pkg::tnlf_load_type                      load,
   input  wire logic [MAX_KEEP-1:0]                          load_valid,
   input  wire logic [MAX_KEEP-1:0][tnlf_pkg::SIZE_BITS-1:0] load_size,
   input  wire logic [MAX_KEEP-1:0][INDEX_BITS-1:0]          load_index,
   output      logic                                         free,
   output      logic                                         rsp_valid,
   input  wire logic                                         rsp_stall,
   output      logic [tnlf_pkg::RANK_BITS-1:0]               rsp_rank,
   output      logic [INDEX_BITS-1:0]                        rsp_file_index,
   output      logic [tnlf_pkg::SIZE_BITS-1:0]               rsp_size_out,
   output      logic                                         rsp_is_empty,
   output      logic                                         rsp_overflowed,
   output      logic                                         rsp_last
);
   import tnlf_pkg::*;

   logic [MAX_KEEP-1:0]                 valid_ff;
   logic [MAX_KEEP-1:0][SIZE_BITS-1:0]  size_ff;
   logic [MAX_KEEP-1:0][INDEX_BITS-1:0] index_ff;
   logic                                empty_ff;
   logic                                ovf_ff;
   logic [RANK_BITS-1:0]                rank_ff;
   logic                                pop;
   logic                                tail_empty;

   assign pop        = valid_ff[0] && !rsp_stall;
   assign tail_empty = ((valid_ff >> 1) == '0);
   // Row can take a new snapshot once the last word leaves
   assign free       = !valid_ff[0] || (tail_empty && !rsp_stall);

   // Valid bits stay contiguous from cell 0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         empty_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (load.en) begin
         valid_ff <= load_valid | MAX_KEEP'(load.empty);
         empty_ff <= load.empty;
         rank_ff  <= '0;
      end else if (pop) begin
         valid_ff <= valid_ff >> 1;
         rank_ff  <= rank_ff + 1'b1;
      end
   end

   // Payload row
   always_ff @(posedge clock) begin
      if (load.en) begin
         size_ff  <= load_size;
         index_ff <= load_index;
         ovf_ff   <= load.overflow;
      end else if (pop) begin
         size_ff  <= size_ff >> SIZE_BITS;
         index_ff <= index_ff >> INDEX_BITS;
      end
   end

   assign rsp_valid      = valid_ff[0];
   assign rsp_rank       = rank_ff;
   assign rsp_file_index = empty_ff ? '0 : index_ff[0];
   assign rsp_size_out   = empty_ff ? '0 : size_ff[0];
   assign rsp_is_empty   = empty_ff;
   assign rsp_overflowed = ovf_ff;
   assign rsp_last       = tail_empty;

endmodule

`default_nettype wire

### hdl/top_n_largest_files.sv
// Top level of the top-N largest files selector.
`default_nettype none

// Keeps the MAX_KEEP largest file sizes of a set in a row of compare-and-shift
// cells, sorted largest first, equal sizes in arrival order. An arrival word is
// never stalled: it is broadcast to all cells and inserted in place in that
// cycle. An end word copies the first min(keep_count, MAX_KEEP) entries into
// an output row and clears the set in the same cycle, so the next set can
// stream in while the result words shift out one per cycle while rsp_stall is
// low. A set with nothing to report yields one word flagged empty. An end word
// waits (req_stall high) only while the output row still holds more than one
// undelivered word of the previous set, or holds its last word while
// rsp_stall is high. Arrivals beyond 2^INDEX_BITS in a set are dropped and
// flagged on every word of that set's report.
module top_n_largest_files #(
   parameter int MAX_KEEP   = tnlf_pkg::MAX_KEEP_DEF,
   parameter int INDEX_BITS = tnlf_pkg::INDEX_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [tnlf_pkg::KEEP_BITS-1:0] csr_keep_count,
   // input words
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_op,
   input  wire logic [tnlf_pkg::SIZE_BITS-1:0] req_file_size,
   // result words
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [tnlf_pkg::RANK_BITS-1:0] rsp_rank,
   output      logic [INDEX_BITS-1:0]          rsp_file_index,
   output      logic [tnlf_pkg::SIZE_BITS-1:0] rsp_size_out,
   output      logic                           rsp_is_empty,
   output      logic                           rsp_overflowed,
   output      logic                           rsp_last
);
   import tnlf_pkg::*;

   localparam int CmpW = 8;

   logic [KEEP_BITS-1:0]                keep_ff;
   logic [INDEX_BITS:0]                 arr_ff;
   logic                                ovf_ff;
   logic                                accept;
   logic                                arrive;
   logic                                finish;
   logic                                full;
   logic                                drain_free;
   logic [MAX_KEEP-1:0]                 take;
   logic [MAX_KEEP-1:0]                 cell_valid;
   logic [MAX_KEEP-1:0][SIZE_BITS-1:0]  cell_size;
   logic [MAX_KEEP-1:0][INDEX_BITS-1:0] cell_index;
   logic [MAX_KEEP-1:0]                 snap_valid;
   tnlf_load_type                       load;

   // Configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_ff <= csr_keep_count;
      end
   end

   // Handshake decode
   assign req_stall = (req_op == OP_END) && !drain_free;
   assign accept    = req_valid && !req_stall;
   assign arrive    = accept && (req_op == OP_ARRIVE);
   assign finish    = accept && (req_op == OP_END);
   assign full      = arr_ff[INDEX_BITS];

   // Arrival counter and overflow flag
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         arr_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (arrive) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            arr_ff <= arr_ff + 1'b1;
         end
      end
   end

   // Sorted insertion row
   for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cell
      logic                 up_take;
      logic                 up_valid;
      logic [SIZE_BITS-1:0] up_size;
      logic [INDEX_BITS-1:0] up_index;

      if (j == 0) begin : g_head
         assign up_take  = 1'b0;
         assign up_valid = 1'b0;
         assign up_size  = '0;
         assign up_index = '0;
      end else begin : g_body
         assign up_take  = take[j-1];
         assign up_valid = cell_valid[j-1];
         assign up_size  = cell_size[j-1];
         assign up_index = cell_index[j-1];
      end

      tnlf_cell #(
         .INDEX_BITS(INDEX_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins_en    (arrive && !full),
         .clear     (finish),
         .new_size  (req_file_size),
         .new_index (arr_ff[INDEX_BITS-1:0]),
         .prev_take (up_take),
         .prev_valid(up_valid),
         .prev_size (up_size),
         .prev_index(up_index),
         .take      (take[j]),
         .valid     (cell_valid[j]),
         .size      (cell_size[j]),
         .index     (cell_index[j])
      );

      // Report only the first keep_count entries
      assign snap_valid[j] = cell_valid[j] && (CmpW'(j) < CmpW'(keep_ff));
   end

   // Snapshot into the output row on an end word
   assign load.en       = finish;
   assign load.empty    = !snap_valid[0];
   assign load.overflow = ovf_ff;

   tnlf_drain #(
      .MAX_KEEP  (MAX_KEEP),
      .INDEX_BITS(INDEX_BITS)
   ) u_drain (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .load_valid    (snap_valid),
      .load_size     (cell_size),
      .load_index    (cell_index),
      .free          (drain_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rank      (rsp_rank),
      .rsp_file_index(rsp_file_index),
      .rsp_size_out  (rsp_size_out),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_overflowed(rsp_overflowed),
      .rsp_last      (rsp_last)
   );

   // An end word always produces a report on the next cycle
   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("end word did not start a report");

   // Ranks count up by one within a report
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && (rsp_rank == RANK_BITS'($past(rsp_rank) + 1'b1)))
      else $error("rank did not advance within a report");

   // An empty report is a single word
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_last)
      else $error("empty report not marked last");

   // Arrival counter stops exactly at the index range
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      arr_ff[INDEX_BITS] |-> (arr_ff[INDEX_BITS-1:0] == '0))
      else $error("arrival counter ran past the index range");

endmodule

`default_nettype wire
